@@ hw/rtl/sm4_pkg.sv @@
// Shared types, constants and round functions for the SM4 block cipher.
`timescale 1ns / 1ps

package sm4_pkg;

   localparam int ROUND_COUNT = 32;
   localparam int ROUND_W     = $clog2(ROUND_COUNT);

   // Register indexes of the configuration port
   localparam logic REG_KEY_HIGH = 1'b0;
   localparam logic REG_KEY_LOW  = 1'b1;

   localparam logic [31:0] FK0 = 32'ha3b1bac6;
   localparam logic [31:0] FK1 = 32'h56aa3350;
   localparam logic [31:0] FK2 = 32'h677d9197;
   localparam logic [31:0] FK3 = 32'hb27022dc;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
      logic        decrypt;
   } req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_LOAD,
      ST_ROUND
   } state_type;

   localparam logic [7:0] SBOX [0:255] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // Byte substitution on all four bytes
   function automatic logic [31:0] tau(input logic [31:0] v);
      return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
   endfunction

   // Data path transform: S-box then L
   function automatic logic [31:0] round_mix(input logic [31:0] v);
      logic [31:0] b;
      b = tau(v);
      return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
               ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
   endfunction

   // Key schedule transform: S-box then L'
   function automatic logic [31:0] key_mix(input logic [31:0] v);
      logic [31:0] b;
      b = tau(v);
      return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
   endfunction

   // CK constant: byte j of word i is 7 * (4i + j) mod 256
   function automatic logic [31:0] ck_word(input logic [ROUND_W-1:0] i);
      logic [31:0] w;
      logic [7:0]  idx;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         idx = 8'({i, 2'(j)});
         w   = {w[23:0], 8'(idx * 8'd7)};
      end
      return w;
   endfunction

endpackage

@@ hw/rtl/sm4_block_cipher_top.sv @@
// SM4 block cipher, ECB mode, with on-chip key expansion and round key memory.
//
// Usage:
//   Load the 128-bit key through csr_we / csr_index / csr_wdata (index 0 is key
//   bits 127..64, index 1 is key bits 63..0) while the block is idle. Any key
//   write marks the stored round keys stale.
//   Raise start with req_payload while busy is low; the request is taken at
//   that edge. decrypt selects the round keys in reverse order.
//   The result appears on rsp_payload for exactly one cycle with rsp_valid.
//   The receiver cannot stall; the result register is separate, so a new
//   request may be taken in the same cycle the result is shown.
// Operation:
//   With current round keys, the rounds run one round per cycle on the
//   shared round unit, one round key read per cycle from the 32 x 32 key
//   RAM, then the result register is loaded; one request at a time.
//   After a key write the first request first runs the key schedule, one
//   round key per cycle into the RAM, then reads the first key in the load
//   state before its rounds start.
// Reset:
//   Synchronous, active high. Keys return to zero and are marked stale; the
//   key RAM content is left as is and is never read before being rewritten.
`timescale 1ns / 1ps

module sm4_block_cipher_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  sm4_pkg::req_type    req_payload,
   output logic                rsp_valid,
   output sm4_pkg::rsp_type    rsp_payload,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [63:0]         csr_wdata
);
   import sm4_pkg::*;

   state_type            state_ff, state_in;
   logic [ROUND_W-1:0]   cnt_ff, cnt_in;
   logic                 dec_ff, dec_in;
   logic [31:0]          x0_ff, x1_ff, x2_ff, x3_ff;
   logic [31:0]          x0_in, x1_in, x2_in, x3_in;
   logic [31:0]          k0_ff, k1_ff, k2_ff, k3_ff;
   logic [31:0]          k0_in, k1_in, k2_in, k3_in;
   logic [63:0]          key_high_ff, key_low_ff;
   logic                 keys_current_ff, keys_current_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_payload_ff, rsp_payload_in;

   // Round key memory
   logic [31:0]          rk_mem [ROUND_COUNT];
   logic [31:0]          rk_rd_ff;
   logic [ROUND_W-1:0]   rd_addr;
   logic                 wr_en;
   logic [31:0]          nk;
   logic [31:0]          nx;
   logic [ROUND_W-1:0]   cnt_next;
   logic                 accept;

   assign accept   = start && (state_ff == ST_IDLE);
   assign cnt_next = cnt_ff + 1'b1;
   assign nk       = k0_ff ^ key_mix(k1_ff ^ k2_ff ^ k3_ff ^ ck_word(cnt_ff));
   assign nx       = x0_ff ^ round_mix(x1_ff ^ x2_ff ^ x3_ff ^ rk_rd_ff);
   assign wr_en    = (state_ff == ST_EXPAND);

   // Write expanded keys, read one round key per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rk_mem[cnt_ff] <= nk;
      end
      rk_rd_ff <= rk_mem[rd_addr];
   end

   // Key registers: any write makes the round keys stale
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_KEY_HIGH: key_high_ff <= csr_wdata;
            REG_KEY_LOW:  key_low_ff  <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         keys_current_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         keys_current_ff <= keys_current_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Data path registers
   always_ff @(posedge clock) begin
      dec_ff         <= dec_in;
      x0_ff          <= x0_in;
      x1_ff          <= x1_in;
      x2_ff          <= x2_in;
      x3_ff          <= x3_in;
      k0_ff          <= k0_in;
      k1_ff          <= k1_in;
      k2_ff          <= k2_in;
      k3_ff          <= k3_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // Sequencer: next state, read address and data path updates
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      dec_in          = dec_ff;
      x0_in           = x0_ff;
      x1_in           = x1_ff;
      x2_in           = x2_ff;
      x3_in           = x3_ff;
      k0_in           = k0_ff;
      k1_in           = k1_ff;
      k2_in           = k2_ff;
      k3_in           = k3_ff;
      keys_current_in = keys_current_ff && !csr_we;
      rsp_valid_in    = 1'b0;
      rsp_payload_in  = rsp_payload_ff;
      rd_addr         = dec_ff ? ~cnt_next : cnt_next;
      case (state_ff)
         ST_IDLE: begin
            rd_addr = req_payload.decrypt ? ROUND_W'(ROUND_COUNT - 1) : '0;
            if (accept) begin
               dec_in = req_payload.decrypt;
               x0_in  = req_payload.block_high[63:32];
               x1_in  = req_payload.block_high[31:0];
               x2_in  = req_payload.block_low[63:32];
               x3_in  = req_payload.block_low[31:0];
               cnt_in = '0;
               if (keys_current_ff) begin
                  state_in = ST_ROUND;
               end else begin
                  k0_in    = key_high_ff[63:32] ^ FK0;
                  k1_in    = key_high_ff[31:0]  ^ FK1;
                  k2_in    = key_low_ff[63:32]  ^ FK2;
                  k3_in    = key_low_ff[31:0]   ^ FK3;
                  state_in = ST_EXPAND;
               end
            end
         end
         ST_EXPAND: begin
            // advance the key schedule, one round key per cycle
            k0_in  = k1_ff;
            k1_in  = k2_ff;
            k2_in  = k3_ff;
            k3_in  = nk;
            cnt_in = cnt_next;
            if (cnt_ff == ROUND_W'(ROUND_COUNT - 1)) begin
               keys_current_in = 1'b1;
               state_in        = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // fetch the first round key
            rd_addr  = dec_ff ? ROUND_W'(ROUND_COUNT - 1) : '0;
            cnt_in   = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            x0_in  = x1_ff;
            x1_in  = x2_ff;
            x2_in  = x3_ff;
            x3_in  = nx;
            cnt_in = cnt_next;
            if (cnt_ff == ROUND_W'(ROUND_COUNT - 1)) begin
               // final word reversal into the result register
               rsp_valid_in               = 1'b1;
               rsp_payload_in.result_high = {nx, x3_ff};
               rsp_payload_in.result_low  = {x2_ff, x1_ff};
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A taken request always makes the block busy
   assert property (@(posedge clock) disable iff (reset) accept |=> busy)
      else $error("request taken but block not busy");

   // A result only follows the last round
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_ROUND && cnt_ff == ROUND_W'(ROUND_COUNT - 1)))
      else $error("result without a completed last round");

   // Result strobe lasts one cycle
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule
